/* design/hvn_pkg.sv */
// ----------------------------------------------------------------------------
// hvn_pkg: shared types and constants for the heightmap vertex normal unit
// sizes, register indexes, operation codes, sequencer and normalize states,
// normalize request and response
package hvn_pkg;

  localparam int unsigned MaxSide    = 512;
  localparam int unsigned SideBits   = $clog2(MaxSide);
  localparam int unsigned HeightBits = 16;
  localparam int unsigned AddrBits   = 2 * SideBits;

  localparam logic [1:0] RegGridWidth  = 2'd0;
  localparam logic [1:0] RegGridHeight = 2'd1;
  localparam logic [1:0] RegHeightGain = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FACE,
    ST_VERT,
    ST_OUT
  } state_e;

  // normalize unit steps
  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DIV,
    N_DONE
  } norm_state_e;

  // request to the normalize unit
  typedef struct packed {
    logic              start;
    logic              vert;
    logic signed [40:0] x;
    logic signed [40:0] y;
    logic signed [40:0] z;
  } norm_req_t;

  typedef struct packed {
    logic              done;
    logic              zero;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } norm_rsp_t;

endpackage

/* design/hvn_norm.sv */
// ----------------------------------------------------------------------------
// hvn_norm: multi-cycle vector normalize
// prescale, squared length, bit-serial isqrt, restoring divide per component
// ----------------------------------------------------------------------------
module hvn_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hvn_pkg::norm_req_t req_i,
  output hvn_pkg::norm_rsp_t rsp_o
);

  hvn_pkg::norm_state_e state_q, state_d;
  logic [40:0] m_q [3];
  logic [2:0]  neg_q;
  logic        vert_q;
  logic [1:0]  k_q;
  logic [63:0] l2_q, rem_q, root_q, bit_q;
  logic [31:0] len_q;
  logic [77:0] num_q;
  logic [77:0] drem_q;
  logic [6:0]  cnt_q;
  logic [31:0] res_q [3];
  logic        zero_q;

  logic [40:0] mx;
  logic [63:0] sq;
  logic [78:0] trial;
  logic [32:0] len2;

  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    sq = 64'(m_q[k_q][29:0]) * 64'(m_q[k_q][29:0]);
    len2 = {len_q, 1'b0};
    trial = {drem_q, num_q[77 - cnt_q]};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hvn_pkg::N_IDLE:  if (req_i.start) state_d = hvn_pkg::N_SHIFT;
      hvn_pkg::N_SHIFT: if (mx < 41'(64'd1 << 30)) state_d = hvn_pkg::N_SQ;
      hvn_pkg::N_SQ:    if (k_q == 2'd2) state_d = hvn_pkg::N_SQRT;
      hvn_pkg::N_SQRT:
        if (bit_q == 64'd0) state_d = (root_q == 64'd0) ? hvn_pkg::N_DONE : hvn_pkg::N_DIV;
      hvn_pkg::N_DIV:   if (cnt_q == 7'd77 && k_q == 2'd2) state_d = hvn_pkg::N_DONE;
      hvn_pkg::N_DONE:  state_d = hvn_pkg::N_IDLE;
      default:          state_d = hvn_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hvn_pkg::N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      hvn_pkg::N_IDLE: begin
        vert_q <= req_i.vert;
        neg_q  <= {req_i.z[40], req_i.y[40], req_i.x[40]};
        m_q[0] <= req_i.x[40] ? 41'(-req_i.x) : req_i.x;
        m_q[1] <= req_i.y[40] ? 41'(-req_i.y) : req_i.y;
        m_q[2] <= req_i.z[40] ? 41'(-req_i.z) : req_i.z;
        k_q    <= 2'd0;
        l2_q   <= 64'd0;
      end
      hvn_pkg::N_SHIFT: begin
        if (mx >= 41'(64'd1 << 30)) begin
          m_q[0] <= m_q[0] >> 1;
          m_q[1] <= m_q[1] >> 1;
          m_q[2] <= m_q[2] >> 1;
        end
      end
      hvn_pkg::N_SQ: begin
        l2_q <= l2_q + sq;
        k_q  <= k_q + 2'd1;
        if (k_q == 2'd2) begin
          rem_q  <= l2_q + sq;
          root_q <= 64'd0;
          bit_q  <= 64'd1 << 62;
        end
      end
      hvn_pkg::N_SQRT: begin
        if (bit_q != 64'd0) begin
          if (rem_q >= root_q + bit_q) begin
            rem_q  <= rem_q - (root_q + bit_q);
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          len_q  <= root_q[31:0];
          zero_q <= (root_q == 64'd0);
          k_q    <= 2'd0;
          cnt_q  <= 7'd0;
          drem_q <= 78'd0;
          // numerator 2*m*one + len
          num_q  <= (78'(m_q[0]) << (vert_q ? 15 : 31)) + 78'(root_q[31:0]);
        end
      end
      hvn_pkg::N_DIV: begin
        if (trial >= 79'(len2)) begin
          res_q[k_q] <= {res_q[k_q][30:0], 1'b1};
        end else begin
          res_q[k_q] <= {res_q[k_q][30:0], 1'b0};
        end
        if (cnt_q == 7'd77) begin
          cnt_q  <= 7'd0;
          drem_q <= 78'd0;
          k_q    <= k_q + 2'd1;
          if (k_q != 2'd2) begin
            num_q <= (78'(m_q[k_q + 2'd1]) << (vert_q ? 15 : 31)) + 78'(len_q);
          end
        end else begin
          cnt_q  <= cnt_q + 7'd1;
          drem_q <= (trial >= 79'(len2)) ? 78'(trial - 79'(len2)) : trial[77:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == hvn_pkg::N_DONE);
    rsp_o.zero = zero_q;
    rsp_o.x = neg_q[0] ? -res_q[0] : res_q[0];
    rsp_o.y = neg_q[1] ? -res_q[1] : res_q[1];
    rsp_o.z = neg_q[2] ? -res_q[2] : res_q[2];
    if (zero_q) begin
      rsp_o.x = '0;
      rsp_o.y = '0;
      rsp_o.z = '0;
    end
  end

endmodule

/* design/heightmap_vertex_normals.sv */
// ----------------------------------------------------------------------------
// heightmap_vertex_normals: smoothed vertex normals over a stored height grid
// ----------------------------------------------------------------------------
// heights live in one 512x512 synchronous ram (undefined until written). a
// write beat stalls the input through a write phase. a query reads three
// heights per touching face, up to twelve, one per cycle through the single
// ram port, then runs each of up to four face normals and the final vertex
// normal through one shared normalize unit (shift prescale, 32-step square
// root, three 78-step restoring divides). a query outside the grid skips the
// faces and goes straight to the output step. one item is in work at a time;
// the result register frees as soon as its beat is taken.
module heightmap_vertex_normals (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation_i,
  input  logic [8:0]          row_i,
  input  logic [8:0]          col_i,
  input  logic [15:0]         height_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  normal_x_o,
  output logic signed [15:0]  normal_y_o,
  output logic signed [15:0]  normal_z_o,
  output logic                status_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  hvn_pkg::state_e state_q, state_d;

  logic [9:0]  width_q, height_q;
  logic [15:0] gain_q;

  // height ram
  logic [hvn_pkg::HeightBits-1:0] mem [hvn_pkg::MaxSide * hvn_pkg::MaxSide];
  logic [hvn_pkg::HeightBits-1:0] rdata_q;
  logic                           we;
  logic [hvn_pkg::AddrBits-1:0]   waddr, raddr;

  logic [8:0]  row_q, col_q;
  logic [1:0]  face_q;      // face index within the 2x2 neighborhood
  logic [1:0]  rd_q;        // fetch step: a, b, c, then c lands
  logic [15:0] ha_q, hb_q;
  logic signed [40:0] acc_x_q, acc_y_q, acc_z_q;
  logic        norm_busy_q;
  logic        wr_phase_q;
  logic        out_valid_q;
  logic [15:0] nx_q, ny_q, nz_q;
  logic        st_q;

  hvn_pkg::norm_req_t nreq;
  hvn_pkg::norm_rsp_t nrsp;

  // face k: fj = row-1+k[1], fi = col-1+k[0]
  logic [9:0] fj, fi;
  logic       face_ok;
  logic       in_grid;

  always_comb begin
    fj = 10'(row_q) - 10'd1 + 10'(face_q[1]);
    fi = 10'(col_q) - 10'd1 + 10'(face_q[0]);
    face_ok = !fj[9] && !fi[9] && (fj < height_q - 10'd1) && (fi < width_q - 10'd1);
    in_grid = (10'(row_i) < height_q) && (10'(col_i) < width_q);
  end

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_q != hvn_pkg::ST_IDLE) || wr_phase_q || out_valid_q;
  assign cfg_ready = 1'b1;

  // ram address of the fetch in flight: a at (fj,fi), b at (fj+1,fi), c at (fj+1,fi+1)
  always_comb begin
    raddr = {9'(fj + 10'(rd_q != 2'd0)), 9'(fi + 10'(rd_q == 2'd2))};
    we    = in_acc && (operation_i == hvn_pkg::OpWrite) && in_grid;
    waddr = {row_i, col_i};
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= height_i;
    rdata_q <= mem[raddr];
  end

  // scaled face vector
  logic signed [33:0] sa, sb, sc, d1, d2;
  always_comb begin
    sa = 34'(ha_q) * 34'(gain_q);
    sb = 34'(hb_q) * 34'(gain_q);
    sc = 34'(rdata_q) * 34'(gain_q);
    d1 = sb - sa;
    d2 = sa - sc;
  end

  always_comb begin
    nreq.start = 1'b0;
    nreq.vert  = (state_q == hvn_pkg::ST_VERT);
    nreq.x = 41'(d1) + 41'(d2);
    nreq.y = 41'sd4096;
    nreq.z = 41'(d1);
    if (state_q == hvn_pkg::ST_VERT) begin
      nreq.x = acc_x_q;
      nreq.y = acc_y_q;
      nreq.z = acc_z_q;
    end
    nreq.start = !norm_busy_q && ((state_q == hvn_pkg::ST_VERT) ||
                 (state_q == hvn_pkg::ST_READ && rd_q == 2'd3));
  end

  hvn_norm u_norm (.clk_i, .rst_ni, .req_i(nreq), .rsp_o(nrsp));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hvn_pkg::ST_IDLE:
        if (in_acc && operation_i == hvn_pkg::OpQuery)
          state_d = in_grid ? hvn_pkg::ST_FACE : hvn_pkg::ST_OUT;
      hvn_pkg::ST_FACE:
        if (!face_ok) state_d = (face_q == 2'd3) ? hvn_pkg::ST_VERT : hvn_pkg::ST_FACE;
        else state_d = hvn_pkg::ST_READ;
      hvn_pkg::ST_READ:
        if (nrsp.done) state_d = (face_q == 2'd3) ? hvn_pkg::ST_VERT : hvn_pkg::ST_FACE;
      hvn_pkg::ST_VERT:
        if (nrsp.done) state_d = hvn_pkg::ST_OUT;
      hvn_pkg::ST_OUT:
        state_d = hvn_pkg::ST_IDLE;
      default: state_d = hvn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hvn_pkg::ST_IDLE;
      width_q     <= 10'd257;
      height_q    <= 10'd257;
      gain_q      <= 16'd4096;
      out_valid_q <= 1'b0;
      wr_phase_q  <= 1'b0;
      norm_busy_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_phase_q <= in_acc && (operation_i == hvn_pkg::OpWrite);
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_i)
          hvn_pkg::RegGridWidth:
            width_q <= (cfg_data_i[9:0] < 10'd2) ? 10'd2 :
                       (cfg_data_i[9:0] > 10'(hvn_pkg::MaxSide)) ?
                       10'(hvn_pkg::MaxSide) : cfg_data_i[9:0];
          hvn_pkg::RegGridHeight:
            height_q <= (cfg_data_i[9:0] < 10'd2) ? 10'd2 :
                        (cfg_data_i[9:0] > 10'(hvn_pkg::MaxSide)) ?
                        10'(hvn_pkg::MaxSide) : cfg_data_i[9:0];
          hvn_pkg::RegHeightGain: gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (nreq.start) norm_busy_q <= 1'b1;
      else if (nrsp.done) norm_busy_q <= 1'b0;
      if (state_q == hvn_pkg::ST_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q   <= row_i;
      col_q   <= col_i;
      st_q    <= !in_grid;
      face_q  <= 2'd0;
      acc_x_q <= '0;
      acc_y_q <= '0;
      acc_z_q <= '0;
    end
    unique case (state_q)
      hvn_pkg::ST_FACE: begin
        rd_q <= 2'd0;
        if (!face_ok) face_q <= face_q + 2'd1;
      end
      hvn_pkg::ST_READ: begin
        // ram data lands in the cycle after its address
        if (rd_q == 2'd1) ha_q <= rdata_q;
        if (rd_q == 2'd2) hb_q <= rdata_q;
        if (rd_q != 2'd3) rd_q <= rd_q + 2'd1;
        if (nrsp.done) begin
          acc_x_q <= acc_x_q + 41'(nrsp.x);
          acc_y_q <= acc_y_q + 41'(nrsp.y);
          acc_z_q <= acc_z_q + 41'(nrsp.z);
          face_q  <= face_q + 2'd1;
        end
      end
      hvn_pkg::ST_VERT: begin
        if (nrsp.done) begin
          nx_q <= nrsp.zero ? 16'd0 : nrsp.x[15:0];
          ny_q <= nrsp.zero ? 16'd16384 : nrsp.y[15:0];
          nz_q <= nrsp.zero ? 16'd0 : nrsp.z[15:0];
        end
      end
      hvn_pkg::ST_OUT: begin
        if (st_q) begin
          nx_q <= '0;
          ny_q <= '0;
          nz_q <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid  = out_valid_q;
  assign normal_x_o = nx_q;
  assign normal_y_o = ny_q;
  assign normal_z_o = nz_q;
  assign status_o   = st_q;

  // a result only appears after the sequencer's output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(state_q == hvn_pkg::ST_OUT))
    else $error("result without output step");

  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input taken with result pending");

  // normalize unit never restarted while busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nreq.start |-> !norm_busy_q)
    else $error("normalize restarted while busy");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for heightmap_vertex_normals
// fills small patches of the height grid, queries smoothed vertex normals and
// compares every result beat against an in-bench fixed-point model, over
// several grid sizes, gains and idle/stall patterns
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [15:0] height;
  } hv_item_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               st;
  } hv_normal_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  logic               operation_i;
  logic [8:0]         row_i;
  logic [8:0]         col_i;
  logic [15:0]        height_i;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] normal_x_o;
  logic signed [15:0] normal_y_o;
  logic signed [15:0] normal_z_o;
  logic               status_o;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;

  heightmap_vertex_normals dut (.*);

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow of the block: heights, which cells were ever written, registers
  logic [15:0]  heights [hvn_pkg::MaxSide*hvn_pkg::MaxSide];
  bit           height_seen [hvn_pkg::MaxSide*hvn_pkg::MaxSide];
  int unsigned  grid_w, grid_h, gain;

  hv_item_t     pending_items[$];
  hv_normal_t   normals_due[$];
  int           send_idle_pct, stall_pct;
  int           errors;

  // ---------------------------------------------------------------- model
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale vector to length one_val; returns 0 for the zero vector
  function automatic bit to_unit(input longint v[3], input longint unsigned one_val,
                                 output longint o[3]);
    longint unsigned m[3];
    longint unsigned mx, len, q;
    bit              neg[3];
    for (int k = 0; k < 3; k++) begin
      neg[k] = v[k] < 0;
      m[k]   = neg[k] ? -v[k] : v[k];
    end
    forever begin
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx < (64'd1 << 30)) break;
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    end
    len = int_sqrt(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]);
    if (len == 0) begin
      o = '{0, 0, 0};
      return 0;
    end
    for (int k = 0; k < 3; k++) begin
      q    = (m[k] * one_val * 2 + len) / (2 * len);
      o[k] = neg[k] ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint scaled(int unsigned r, int unsigned c);
    return longint'(heights[r*hvn_pkg::MaxSide + c]) * longint'(gain);
  endfunction

  function automatic void face_sum(int unsigned fj, int unsigned fi, inout longint acc[3]);
    longint a, d1, d2;
    longint v[3], n[3];
    a  = scaled(fj, fi);
    d1 = scaled(fj + 1, fi) - a;
    d2 = a - scaled(fj + 1, fi + 1);
    v  = '{d1 + d2, 4096, d1};
    void'(to_unit(v, 64'd1 << 30, n));
    for (int k = 0; k < 3; k++) acc[k] += n[k];
  endfunction

  // apply one accepted input beat to the shadow state, queue its normal
  function automatic void apply_item(logic op, int unsigned j, int unsigned i,
                                     logic [15:0] h);
    longint     acc[3], n[3];
    hv_normal_t e;
    if (op == hvn_pkg::OpWrite) begin
      if (j < grid_h && i < grid_w) heights[j*hvn_pkg::MaxSide + i] = h;
      return;
    end
    e = '{0, 0, 0, 1'b1};
    if (j < grid_h && i < grid_w) begin
      acc = '{0, 0, 0};
      if (j >= 1 && i >= 1)                  face_sum(j - 1, i - 1, acc);
      if (j >= 1 && i < grid_w - 1)          face_sum(j - 1, i, acc);
      if (j < grid_h - 1 && i >= 1)          face_sum(j, i - 1, acc);
      if (j < grid_h - 1 && i < grid_w - 1)  face_sum(j, i, acc);
      // opposing faces cancel: straight up
      if (!to_unit(acc, 16384, n)) n = '{0, 16384, 0};
      e = '{n[0][15:0], n[1][15:0], n[2][15:0], 1'b0};
    end
    normals_due.push_back(e);
  endfunction

  // ------------------------------------------------------------ stimulus
  function automatic bit cell_ok(int unsigned r, int unsigned c);
    return height_seen[r*hvn_pkg::MaxSide + c];
  endfunction

  function automatic bit face_ok(int unsigned fj, int unsigned fi);
    return cell_ok(fj, fi) && cell_ok(fj + 1, fi) && cell_ok(fj + 1, fi + 1);
  endfunction

  // a query never touches a height that was never written
  function automatic bit query_ok(int unsigned j, int unsigned i);
    if (j >= grid_h || i >= grid_w) return 1;
    if (j >= 1 && i >= 1 && !face_ok(j - 1, i - 1)) return 0;
    if (j >= 1 && i < grid_w - 1 && !face_ok(j - 1, i)) return 0;
    if (j < grid_h - 1 && i >= 1 && !face_ok(j, i - 1)) return 0;
    if (j < grid_h - 1 && i < grid_w - 1 && !face_ok(j, i)) return 0;
    return 1;
  endfunction

  function automatic logic [15:0] rand_height();
    return ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom);
  endfunction

  function automatic void push_write(int unsigned j, int unsigned i, logic [15:0] h);
    pending_items.push_back('{hvn_pkg::OpWrite, 9'(j), 9'(i), h});
    if (j < grid_h && i < grid_w) height_seen[j*hvn_pkg::MaxSide + i] = 1'b1;
  endfunction

  function automatic void push_query(int unsigned j, int unsigned i);
    pending_items.push_back('{hvn_pkg::OpQuery, 9'(j), 9'(i), 16'($urandom)});
  endfunction

  // fill the neighborhood of one vertex, then ask for its normal
  function automatic void vertex_burst();
    int unsigned j, i, lo_j, lo_i;
    case ($urandom_range(3))
      0: begin
        j = $urandom_range(grid_h - 1);
        i = $urandom_range(grid_w - 1);
      end
      1: begin
        j = $urandom_range(grid_h < 6 ? grid_h - 1 : 5);
        i = $urandom_range(grid_w < 6 ? grid_w - 1 : 5);
      end
      2: begin
        lo_j = grid_h < 6 ? 0 : grid_h - 6;
        lo_i = grid_w < 6 ? 0 : grid_w - 6;
        j = $urandom_range(grid_h - 1, lo_j);
        i = $urandom_range(grid_w - 1, lo_i);
      end
      default: begin
        j = $urandom_range(1) ? grid_h - 1 : 0;
        i = $urandom_range(grid_w - 1);
      end
    endcase
    for (int r = int'(j) - 1; r <= int'(j) + 1; r++)
      for (int c = int'(i) - 1; c <= int'(i) + 1; c++)
        if (r >= 0 && c >= 0 && r < int'(grid_h) && c < int'(grid_w))
          if (!cell_ok(r, c) || $urandom_range(9) < 3) push_write(r, c, rand_height());
    push_query(j, i);
  endfunction

  // unconstrained beat; a query that would read unwritten cells becomes a write
  function automatic void noise_item();
    int unsigned j, i;
    j = $urandom_range(511);
    i = $urandom_range(511);
    if ($urandom_range(1) && query_ok(j, i)) push_query(j, i);
    else push_write(j, i, 16'($urandom));
  endfunction

  // ------------------------------------------------------------ driver
  always @(posedge clk_i or negedge rst_ni) begin
    hv_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (!in_valid || !in_stall) begin
        // beat taken at this edge: predict from the values it carried
        if (in_valid) apply_item(operation_i, row_i, col_i, height_i);
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_valid    <= 1'b1;
          operation_i <= it.op;
          row_i       <= it.row;
          col_i       <= it.col;
          height_i    <= it.height;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------ monitor
  always @(posedge clk_i or negedge rst_ni) begin
    hv_normal_t e;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (out_valid && !out_stall) begin
        if (normals_due.size() == 0) begin
          $display("%t: unexpected result beat %0d %0d %0d st %0b", $realtime,
                   normal_x_o, normal_y_o, normal_z_o, status_o);
          errors++;
        end else begin
          e = normals_due.pop_front();
          if (normal_x_o !== e.nx) begin
            $display("%t: normal_x exp %0d got %0d", $realtime, e.nx, normal_x_o);
            errors++;
          end
          if (normal_y_o !== e.ny) begin
            $display("%t: normal_y exp %0d got %0d", $realtime, e.ny, normal_y_o);
            errors++;
          end
          if (normal_z_o !== e.nz) begin
            $display("%t: normal_z exp %0d got %0d", $realtime, e.nz, normal_z_o);
            errors++;
          end
          if (status_o !== e.st) begin
            $display("%t: status exp %0b got %0b", $realtime, e.st, status_o);
            errors++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------ sequencing
  function automatic int unsigned side_clamp(logic [15:0] v);
    int unsigned s;
    s = v[9:0];
    if (s < 2) return 2;
    if (s > hvn_pkg::MaxSide) return hvn_pkg::MaxSide;
    return s;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hvn_pkg::RegGridWidth:  grid_w = side_clamp(data);
      hvn_pkg::RegGridHeight: grid_h = side_clamp(data);
      default:                gain   = data;
    endcase
  endtask

  // block idle: all beats sent, all normals back, a write possibly finishing
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || normals_due.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 66; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 66; end
      default: begin send_idle_pct = 9; stall_pct = 9; end
    endcase
  endtask

  logic [15:0] phase_cfg [6][3] = '{
    '{16'd257,   16'd257, 16'd4096},
    '{16'd2,     16'd2,   16'd65535},
    '{16'hFFFF,  16'd512, 16'd0},    // width saturates high, flat terrain
    '{16'd0,     16'd9,   16'd1},    // width saturates low
    '{16'd37,    16'd1,   16'd12345},
    '{16'd512,   16'd300, 16'd4096}
  };

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    operation_i = hvn_pkg::OpWrite;
    row_i       = '0;
    col_i       = '0;
    height_i    = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index_i = hvn_pkg::RegGridWidth;
    cfg_data_i  = '0;
    errors      = 0;
    grid_w      = 257;
    grid_h      = 257;
    gain        = 4096;
    set_idling(0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners, extreme heights, out-of-grid traffic
    push_write(0, 0, 16'h0000);
    push_write(0, 1, 16'hFFFF);
    push_write(0, 2, 16'h8000);
    push_write(1, 0, 16'h0001);
    push_write(1, 1, 16'hFFFF);
    push_write(1, 2, 16'h0000);
    push_write(2, 0, 16'h7FFF);
    push_write(2, 1, 16'h5555);
    push_write(2, 2, 16'hAAAA);
    push_query(0, 0);
    push_query(1, 1);
    push_query(0, 1);
    push_write(255, 255, 16'hFFFF);
    push_write(255, 256, 16'h0000);
    push_write(256, 255, 16'h0000);
    push_write(256, 256, 16'hFFFF);
    push_query(256, 256);
    push_write(400, 400, 16'h1234);  // outside grid, dropped
    push_query(300, 5);              // outside grid, error status
    push_query(511, 511);
    push_query(5, 257);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        wait_idle();
        reg_write(hvn_pkg::RegGridWidth,  phase_cfg[p][0]);
        reg_write(hvn_pkg::RegGridHeight, phase_cfg[p][1]);
        reg_write(hvn_pkg::RegHeightGain, phase_cfg[p][2]);
      end
      set_idling(p % 4);
      // random beats; about five in six picks are well-formed vertex bursts, the rest single noise beats
      for (int n = 0; n < 125; ) begin
        int before_cnt;
        before_cnt = pending_items.size();
        if ($urandom_range(5) == 0) noise_item();
        else vertex_burst();
        n += pending_items.size() - before_cnt;
      end
    end

    wait_idle();
    repeat (2000) @(posedge clk_i);
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
